// ===== design/gdw_pkg.sv =====
// Package for the graph walk core: command and result words, opcodes, status codes.
// No dependencies.
`timescale 1ns / 1ps
package gdw_pkg;

   localparam logic [2:0] OP_CLEAR    = 3'd0;
   localparam logic [2:0] OP_ADD_NODE = 3'd1;
   localparam logic [2:0] OP_ADD_EDGE = 3'd2;
   localparam logic [2:0] OP_DFS      = 3'd3;
   localparam logic [2:0] OP_BFS      = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_ID   = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   localparam int MAX_RESULTS = 8;

   typedef struct packed {
      logic [2:0] opcode;
      logic [3:0] first_id;
      logic [3:0] second_id;
   } req_type;

   typedef struct packed {
      logic [3:0] node_id;
      logic [2:0] status;
      logic       last;
   } rsp_type;

endpackage

// ===== design/gdw_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gdw_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== design/gdw_fifo.sv =====
// Short command queue between the front and back parts.
// Depends on gdw_pkg.
`timescale 1ns / 1ps
module gdw_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_full,
   input  gdw_pkg::req_type in_word,
   output logic             out_valid,
   input  logic             out_take,
   output gdw_pkg::req_type out_word
);
   gdw_pkg::req_type slot_ff [2];
   logic             rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign in_full   = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_word  = slot_ff[rd_ff];
   assign push      = in_valid && !in_full;
   assign pop       = out_take && out_valid;

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= in_word;
      end
   end
endmodule

// ===== design/gdw_engine.sv =====
// Back part: graph store, add commands and depth/breadth-first walks.
// Depends on gdw_pkg and gdw_ram.
`timescale 1ns / 1ps
module gdw_engine #(
   parameter int MAX_NODES  = 8,
   parameter int MAX_DEGREE = 8,
   parameter int WORK_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  gdw_pkg::req_type cmd_word,
   output logic             out_valid,
   input  logic             out_stall,
   output gdw_pkg::rsp_type out_word
);
   localparam int NW = $clog2(MAX_NODES);
   localparam int DW = $clog2(MAX_DEGREE + 1);
   localparam int SW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int TD = MAX_NODES * MAX_DEGREE;
   localparam int TW = $clog2(TD);
   localparam int WW = $clog2(WORK_DEPTH);
   localparam int FW = $clog2(WORK_DEPTH + 1);
   localparam int RW = $clog2(gdw_pkg::MAX_RESULTS + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_EDGE2 = 8'b0000_0010,
      S_POP   = 8'b0000_0100,
      S_PWAIT = 8'b0000_1000,
      S_VISIT = 8'b0001_0000,
      S_NBRD  = 8'b0010_0000,
      S_NBCHK = 8'b0100_0000,
      S_EMIT  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [MAX_NODES-1:0] present_ff, present_in, visited_ff, visited_in;
   logic [3:0]        start_ff, start_in;
   logic [DW-1:0]     count_ff [MAX_NODES];
   logic [DW-1:0]     count_in [MAX_NODES];
   gdw_pkg::req_type  cmd_ff, cmd_in;
   logic              dfs_ff, dfs_in;
   logic [WW-1:0]     head_ff, head_in, tail_ff, tail_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [3:0]        cur_ff, cur_in;
   logic [SW-1:0]     k_ff, k_in;
   logic [RW-1:0]     n_ff, n_in;
   logic              ovalid_ff, ovalid_in;
   gdw_pkg::rsp_type  oword_ff, oword_in;
   logic              after_ff, after_in; // S_EMIT cause: 1 = overflow, 0 = result limit

   // ram ports
   logic              t_we;
   logic [TW-1:0]     t_wa, t_ra;
   logic [3:0]        t_wd, t_rd;
   logic              w_we;
   logic [WW-1:0]     w_wa, w_ra;
   logic [3:0]        w_wd, w_rd;

   gdw_ram #(.WIDTH(4), .DEPTH(TD)) u_tab (
      .clock, .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd),
      .rd_addr(t_ra), .rd_data(t_rd));
   gdw_ram #(.WIDTH(4), .DEPTH(WORK_DEPTH)) u_work (
      .clock, .wr_en(w_we), .wr_addr(w_wa), .wr_data(w_wd),
      .rd_addr(w_ra), .rd_data(w_rd));

   function automatic logic id_ok(input logic [3:0] id);
      id_ok = (id != 4'd0) && ({28'd0, id} <= MAX_NODES);
   endfunction

   function automatic logic [TW-1:0] taddr(input logic [3:0] id, input logic [DW-1:0] k);
      taddr = TW'((32'(id) - 32'd1) * MAX_DEGREE + 32'(k));
   endfunction

   function automatic logic [WW-1:0] wdec(input logic [WW-1:0] p);
      wdec = (p == '0) ? WW'(WORK_DEPTH - 1) : p - WW'(1);
   endfunction

   function automatic logic [WW-1:0] winc(input logic [WW-1:0] p);
      winc = (p == WW'(WORK_DEPTH - 1)) ? '0 : p + WW'(1);
   endfunction

   logic              out_free;
   logic [NW-1:0]     ai, bi, nbi;
   logic              a_ok, b_ok;
   logic [DW-1:0]     ca, cb, scnt;
   logic [WW-1:0]     ptop;

   assign out_valid = ovalid_ff;
   assign out_word  = oword_ff;
   assign out_free  = !ovalid_ff || !out_stall;
   assign ai   = NW'(cmd_ff.first_id - 4'd1);
   assign bi   = NW'(cmd_ff.second_id - 4'd1);
   assign nbi  = NW'(t_rd - 4'd1);
   assign a_ok = id_ok(cmd_ff.first_id) && present_ff[ai];
   assign b_ok = id_ok(cmd_ff.second_id) && present_ff[bi];
   assign ca   = count_ff[ai];
   assign cb   = count_ff[bi];
   assign scnt = count_ff[ai];
   assign ptop = wdec(head_ff);
   assign cmd_take = (state_ff == S_IDLE) && out_free;

   always_comb begin
      state_in   = state_ff;
      present_in = present_ff;
      visited_in = visited_ff;
      start_in   = start_ff;
      count_in   = count_ff;
      cmd_in     = cmd_ff;
      dfs_in     = dfs_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      cur_in     = cur_ff;
      k_in       = k_ff;
      n_in       = n_ff;
      after_in   = after_ff;
      ovalid_in  = ovalid_ff && out_stall;
      oword_in   = oword_ff;
      t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
      w_we = 1'b0; w_wa = '0; w_wd = '0;
      w_ra = dfs_ff ? head_ff : wdec(tail_ff);

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_in = cmd_word;
               ovalid_in = 1'b0;
               case (cmd_word.opcode)
                  gdw_pkg::OP_CLEAR: begin
                     present_in = '0;
                     visited_in = '0;
                     start_in   = 4'd0;
                     for (int i = 0; i < MAX_NODES; i++) count_in[i] = '0;
                     head_in = '0; tail_in = '0; fill_in = '0;
                     ovalid_in = 1'b1;
                     oword_in  = '{4'd0, gdw_pkg::ST_OK, 1'b1};
                  end
                  gdw_pkg::OP_ADD_NODE: begin
                     ovalid_in = 1'b1;
                     if (!id_ok(cmd_word.first_id) ||
                         present_ff[NW'(cmd_word.first_id - 4'd1)]) begin
                        oword_in = '{4'd0, gdw_pkg::ST_BAD_ID, 1'b1};
                     end else begin
                        present_in[NW'(cmd_word.first_id - 4'd1)] = 1'b1;
                        if (start_ff == 4'd0) start_in = cmd_word.first_id;
                        oword_in = '{4'd0, gdw_pkg::ST_OK, 1'b1};
                     end
                  end
                  gdw_pkg::OP_ADD_EDGE: state_in = S_EDGE2;
                  gdw_pkg::OP_DFS, gdw_pkg::OP_BFS: begin
                     if (!id_ok(start_ff) || !present_ff[NW'(start_ff - 4'd1)]) begin
                        ovalid_in = 1'b1;
                        oword_in  = '{4'd0, gdw_pkg::ST_EMPTY, 1'b1};
                     end else begin
                        dfs_in     = (cmd_word.opcode == gdw_pkg::OP_DFS);
                        visited_in = '0;
                        // push start: head goes to top slot, tail stays at zero
                        head_in = WW'(WORK_DEPTH - 1);
                        tail_in = '0;
                        fill_in = FW'(1);
                        w_we = 1'b1; w_wa = WW'(WORK_DEPTH - 1); w_wd = start_ff;
                        n_in = '0;
                        state_in = S_POP;
                     end
                  end
                  default: begin
                     ovalid_in = 1'b1;
                     oword_in  = '{4'd0, gdw_pkg::ST_OK, 1'b1};
                  end
               endcase
            end
         end
         S_EDGE2: begin
            // one table write per cycle; first write here, second here or skipped
            ovalid_in = 1'b1;
            state_in  = S_IDLE;
            if (!a_ok || !b_ok) begin
               oword_in = '{4'd0, gdw_pkg::ST_BAD_ID, 1'b1};
            end else if (cmd_ff.first_id == cmd_ff.second_id) begin
               if (32'(ca) + 2 > MAX_DEGREE) begin
                  oword_in = '{4'd0, gdw_pkg::ST_FULL, 1'b1};
               end else begin
                  t_we = 1'b1; t_wa = taddr(cmd_ff.first_id, ca);
                  t_wd = cmd_ff.first_id;
                  count_in[ai] = ca + DW'(1);
                  cmd_in.opcode = gdw_pkg::OP_CLEAR; // second half pending
                  ovalid_in = 1'b0;
                  state_in  = S_EDGE2;
                  oword_in  = '{4'd0, gdw_pkg::ST_OK, 1'b1};
               end
            end else if (32'(ca) >= MAX_DEGREE || 32'(cb) >= MAX_DEGREE) begin
               oword_in = '{4'd0, gdw_pkg::ST_FULL, 1'b1};
            end else begin
               t_we = 1'b1; t_wa = taddr(cmd_ff.first_id, ca); t_wd = cmd_ff.second_id;
               count_in[ai] = ca + DW'(1);
               cmd_in.first_id  = cmd_ff.second_id;
               cmd_in.second_id = cmd_ff.first_id;
               cmd_in.opcode    = gdw_pkg::OP_CLEAR; // second half pending
               ovalid_in = 1'b0;
               state_in  = S_EDGE2;
            end
            // second half of an edge (opcode rewritten to mark it)
            if (cmd_ff.opcode == gdw_pkg::OP_CLEAR) begin
               t_we = 1'b1; t_wa = taddr(cmd_ff.first_id, ca); t_wd = cmd_ff.second_id;
               count_in = count_ff;
               count_in[ai] = ca + DW'(1);
               cmd_in = cmd_ff;
               ovalid_in = 1'b1;
               state_in  = S_IDLE;
               oword_in  = '{4'd0, gdw_pkg::ST_OK, 1'b1};
            end
         end
         S_POP: begin
            if (fill_ff == '0) begin
               if (out_free) begin
                  ovalid_in = 1'b1;
                  oword_in  = '{4'd0, gdw_pkg::ST_OK, 1'b1};
                  // the last emitted node is held back in cur_ff for marking
                  oword_in.node_id = cur_ff;
                  state_in = S_IDLE;
               end
            end else begin
               if (dfs_ff) head_in = winc(head_ff);
               else tail_in = wdec(tail_ff);
               fill_in = fill_ff - FW'(1);
               state_in = S_PWAIT;
            end
         end
         S_PWAIT: begin
            state_in = S_VISIT;
         end
         S_VISIT: begin
            // w_rd now holds the popped id; emission of the previous node is deferred
            if (!id_ok(w_rd)) begin
               state_in = S_POP;
            end else if (!visited_ff[NW'(w_rd - 4'd1)]) begin
               if (out_free) begin
                  if (n_ff != '0) begin
                     ovalid_in = 1'b1;
                     oword_in  = '{cur_ff, gdw_pkg::ST_OK, 1'b0};
                  end
                  visited_in[NW'(w_rd - 4'd1)] = 1'b1;
                  cur_in = w_rd;
                  cmd_in.first_id = w_rd;
                  n_in = n_ff + RW'(1);
                  k_in = '0;
                  if (32'(n_ff) + 1 >= gdw_pkg::MAX_RESULTS) begin
                     after_in = 1'b0;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_NBRD;
                  end
               end else begin
                  state_in = S_PWAIT; // re-read next cycle (pointer moved; hold via addr below)
               end
            end else begin
               cur_in = cur_ff;
               k_in = '0;
               after_in = 1'b1;
               // scan neighbours of the popped node; remember it separately
               cmd_in.first_id = w_rd;
               state_in = S_NBRD;
            end
         end
         S_NBRD: begin
            state_in = S_NBCHK;
         end
         S_NBCHK: begin
            state_in = S_NBRD;
            if (32'(k_ff) < 32'(scnt) && id_ok(t_rd) && !visited_ff[nbi]) begin
               if (fill_ff == FW'(WORK_DEPTH)) begin
                  after_in = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  w_we = 1'b1; w_wa = ptop; w_wd = t_rd;
                  head_in = ptop;
                  fill_in = fill_ff + FW'(1);
               end
            end
            if (state_in == S_NBRD) begin
               if (32'(k_ff) + 1 >= 32'(scnt)) begin
                  state_in = S_POP;
               end else begin
                  k_in = k_ff + SW'(1);
               end
            end
         end
         S_EMIT: begin
            // result limit (after_ff=0) or overflow (after_ff=1)
            if (out_free) begin
               ovalid_in = 1'b1;
               if (after_ff) begin
                  if (n_ff != '0) begin
                     oword_in = '{cur_ff, gdw_pkg::ST_OK, 1'b0};
                     n_in = '0;
                  end else begin
                     oword_in = '{4'd0, gdw_pkg::ST_OVERFLOW, 1'b1};
                     state_in = S_IDLE;
                  end
               end else begin
                  oword_in = '{cur_ff, gdw_pkg::ST_OK, 1'b1};
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      // neighbour table read address follows the node being scanned
      if (state_ff == S_VISIT || state_ff == S_NBCHK)
         t_ra = taddr(cmd_in.first_id, DW'(k_in));
      else
         t_ra = taddr(cmd_ff.first_id, DW'(k_ff));
      // a popped slot is re-read from its old position while waiting
      if (state_ff == S_PWAIT || state_ff == S_VISIT)
         w_ra = dfs_ff ? wdec(head_ff) : tail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         present_ff <= '0;
         visited_ff <= '0;
         start_ff   <= 4'd0;
         for (int i = 0; i < MAX_NODES; i++) count_ff[i] <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         fill_ff    <= '0;
         ovalid_ff  <= 1'b0;
         n_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         present_ff <= present_in;
         visited_ff <= visited_in;
         start_ff   <= start_in;
         count_ff   <= count_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         fill_ff    <= fill_in;
         ovalid_ff  <= ovalid_in;
         n_ff       <= n_in;
      end
      cmd_ff   <= cmd_in;
      dfs_ff   <= dfs_in;
      cur_ff   <= cur_in;
      k_ff     <= k_in;
      after_ff <= after_in;
      oword_ff <= oword_in;
   end
endmodule

// ===== design/graph_dfs_bfs_walk_core.sv =====
// Graph walk core: undirected graph store with depth- and breadth-first walks.
// Commands enter on req_*, results leave on rsp_*; each command gives one or more
// result words, the final one with last set.
// Sequencing: node, clear and unknown commands are answered from the idle state;
// add edge also passes the edge state, entered again for the second table write
// when it appends (one neighbour-table write per cycle). A walk pops, waits and
// visits each work-list entry, then reads and checks its neighbour slots in turn,
// set by the single read port of the neighbour table and work list; no new
// command is taken until the walk is done. With the engine idle, node and clear
// results appear in the cycle after acceptance, add edge ones from the edge state;
// a walk presents its first node when it visits the second node or finishes.
// A 2-entry command queue sits between the front (req_stall) and the engine,
// so up to two commands can enter while the engine walks or the receiver stalls.
// While rsp_stall is high the result word is held and the engine pauses where it must present a word.
// Reset (synchronous, active high) empties the graph, the queue and the output;
// the neighbour table and work list memories need no clearing.
// Depends on gdw_pkg, gdw_fifo, gdw_engine, gdw_ram.
`timescale 1ns / 1ps
module graph_dfs_bfs_walk_core #(
   parameter int MAX_NODES  = 8,
   parameter int MAX_DEGREE = 8,
   parameter int WORK_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gdw_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gdw_pkg::rsp_type rsp_word
);
   logic             q_valid, q_take;
   gdw_pkg::req_type q_word;

   gdw_fifo u_fifo (
      .clock, .reset,
      .in_valid(req_valid), .in_full(req_stall), .in_word(req_word),
      .out_valid(q_valid), .out_take(q_take), .out_word(q_word));

   gdw_engine #(.MAX_NODES(MAX_NODES), .MAX_DEGREE(MAX_DEGREE),
                .WORK_DEPTH(WORK_DEPTH)) u_engine (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_take(q_take), .cmd_word(q_word),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_word(rsp_word));

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.node_id != 4'd0 |-> rsp_word.status == gdw_pkg::ST_OK)
      else $error("node word with error status");
   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != gdw_pkg::ST_OK |-> rsp_word.last)
      else $error("error word not marked last");
endmodule
